### design/fdbb_pkg.sv
// Shared types and constants for the frame difference bounding box block.
package fdbb_pkg;

  localparam int unsigned MAX_DIMENSION_DEF = 4096;
  localparam int unsigned CFG_W             = 13;
  localparam int unsigned REG_IDX_W         = 1;
  localparam int unsigned CHAN_W            = 8;
  localparam int unsigned CHANGE_THRESHOLD  = 8;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] first_red;
    logic [CHAN_W-1:0] first_green;
    logic [CHAN_W-1:0] first_blue;
    logic [CHAN_W-1:0] first_alpha;
    logic [CHAN_W-1:0] second_red;
    logic [CHAN_W-1:0] second_green;
    logic [CHAN_W-1:0] second_blue;
    logic [CHAN_W-1:0] second_alpha;
  } pixel_pair_t;

  typedef struct packed {
    logic [12:0] rect_x;
    logic [12:0] rect_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic        any_changed;
  } rect_t;

endpackage

### design/fdbb_if.sv
// Valid/ready channel interfaces for pixel pairs and result rectangles.
interface fdbb_pix_if;
  import fdbb_pkg::*;
  logic        valid;
  logic        ready;
  pixel_pair_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fdbb_rect_if;
  import fdbb_pkg::*;
  logic  valid;
  logic  ready;
  rect_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/frame_difference_bounding_box_top.sv
// Frame difference bounding box: change detection and extent tracking per frame.
//
//   channel    dir  handshake          payload
//   pix_in     in   valid/ready        pixel_pair_t (two RGBA pixels)
//   rect_out   out  valid/ready        rect_t (one per frame, on last pixel)
//   cfg        in   cfg_we_i only      frame_width / frame_height, 13 bits
//
// One pixel pair is taken every cycle unless the input stage stalls; rect_out.valid rises at the edge
// that moves the frame's last pixel from the input stage into the result register.
// The input stage keeps taking pairs while a rectangle waits on rect_out, and
// stalls only when it holds a frame's last pixel and the result register is still full.
// Reset leaves both dimensions at 1 and restarts the frame; any register write
// restarts the frame as well.
module frame_difference_bounding_box_top #(
  parameter int unsigned MAX_DIMENSION = fdbb_pkg::MAX_DIMENSION_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fdbb_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [fdbb_pkg::CFG_W-1:0]     cfg_wdata_i,
  fdbb_pix_if.sink                       pix_in,
  fdbb_rect_if.source                    rect_out
);
  import fdbb_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_DIMENSION);
  localparam int unsigned DimW = CntW + 1;

  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [DimW-1:0]  eff_width, eff_height;

  logic [CntW-1:0]  col_q, row_q;
  logic [CntW-1:0]  min_col_q, max_col_q, min_row_q, max_row_q;
  logic [CntW-1:0]  min_col_d, max_col_d, min_row_d, max_row_d;
  logic             seen_q, seen_d;

  logic             s1_valid_q, s1_chg_q;
  logic             s1_adv, last_col, last_row, last_pixel;

  logic [CHAN_W+1:0] sum_a, sum_b;
  logic [CHAN_W-1:0] avg_a, avg_b;
  logic              chg_c;

  rect_t             rect_d, rect_q;
  logic              out_valid_q;

  // Clamp a dimension register to 1..MAX_DIMENSION.
  function automatic logic [DimW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (32'(v) > MAX_DIMENSION) begin
      r = DimW'(MAX_DIMENSION);
    end else begin
      r = DimW'(v);
    end
    return r;
  endfunction

  assign eff_width  = clamp_dim(frame_width_q);
  assign eff_height = clamp_dim(frame_height_q);

  // Floored four-channel averages and the change test.
  always_comb begin
    sum_a = 10'(pix_in.data.first_red) + 10'(pix_in.data.first_green)
          + 10'(pix_in.data.first_blue) + 10'(pix_in.data.first_alpha);
    sum_b = 10'(pix_in.data.second_red) + 10'(pix_in.data.second_green)
          + 10'(pix_in.data.second_blue) + 10'(pix_in.data.second_alpha);
    avg_a = sum_a[CHAN_W+1:2];
    avg_b = sum_b[CHAN_W+1:2];
    if (avg_a >= avg_b) begin
      chg_c = (avg_a - avg_b) >= CHAN_W'(CHANGE_THRESHOLD);
    end else begin
      chg_c = (avg_b - avg_a) >= CHAN_W'(CHANGE_THRESHOLD);
    end
  end

  // Only a frame's last pixel needs room in the result register.
  assign s1_adv       = s1_valid_q && (!last_pixel || !out_valid_q || rect_out.ready);
  assign pix_in.ready = !s1_valid_q || s1_adv;

  assign last_col   = DimW'(col_q) >= (eff_width - DimW'(1));
  assign last_row   = DimW'(row_q) >= (eff_height - DimW'(1));
  assign last_pixel = last_col && last_row;

  // Extents including the pixel in the input stage.
  always_comb begin
    min_col_d = min_col_q;
    max_col_d = max_col_q;
    min_row_d = min_row_q;
    max_row_d = max_row_q;
    if (s1_chg_q) begin
      if (!seen_q || col_q < min_col_q) min_col_d = col_q;
      if (!seen_q || col_q > max_col_q) max_col_d = col_q;
      if (!seen_q || row_q < min_row_q) min_row_d = row_q;
      if (!seen_q || row_q > max_row_q) max_row_d = row_q;
    end
    seen_d = seen_q || s1_chg_q;
  end

  always_comb begin
    if (seen_d) begin
      rect_d.rect_x      = 13'(min_col_d);
      rect_d.rect_y      = 13'(min_row_d);
      rect_d.rect_width  = 16'(max_col_d) - 16'(min_col_d) + 16'd1;
      rect_d.rect_height = 16'(max_row_d) - 16'(min_row_d) + 16'd1;
      rect_d.any_changed = 1'b1;
    end else begin
      rect_d.rect_x      = 13'(eff_width);
      rect_d.rect_y      = 13'(eff_height);
      rect_d.rect_width  = 16'd1 - 16'(eff_width);
      rect_d.rect_height = 16'd1 - 16'(eff_height);
      rect_d.any_changed = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CFG_W'(1);
      frame_height_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_in.valid && pix_in.ready) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_in.valid && pix_in.ready) begin
      s1_chg_q <= chg_c;
    end
  end

  // Position and seen flag; restart on a register write or after the last pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      priority if (cfg_we_i) begin
        col_q  <= '0;
        row_q  <= '0;
        seen_q <= 1'b0;
      end else if (s1_adv && last_pixel) begin
        col_q  <= '0;
        row_q  <= '0;
        seen_q <= 1'b0;
      end else if (s1_adv && last_col) begin
        col_q  <= '0;
        row_q  <= row_q + CntW'(1);
        seen_q <= seen_d;
      end else if (s1_adv) begin
        col_q  <= col_q + CntW'(1);
        seen_q <= seen_d;
      end else begin
        // hold
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      min_col_q <= min_col_d;
      max_col_q <= max_col_d;
      min_row_q <= min_row_d;
      max_row_q <= max_row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && last_pixel) begin
      out_valid_q <= 1'b1;
    end else if (rect_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && last_pixel) begin
      rect_q <= rect_d;
    end
  end

  assign rect_out.valid = out_valid_q;
  assign rect_out.data  = rect_q;

  // Column and row counters stay inside the frame.
  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DimW'(col_q) < eff_width)
    else $error("column counter outside frame");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DimW'(row_q) < eff_height)
    else $error("row counter outside frame");

  a_restart_after_rect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && last_pixel) |=> (col_q == '0 && row_q == '0 && !seen_q && out_valid_q))
    else $error("frame not restarted after result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rect_out.ready) |=> $stable(rect_q))
    else $error("pending result overwritten");

endmodule

### tb/tb_frame_difference_bounding_box_top.sv
// Self-checking testbench for the frame difference bounding box block.
module tb_frame_difference_bounding_box_top;
  import fdbb_pkg::*;

  // Per-frame change tracker: predicts the rectangle each frame should produce.
  class frame_rect_tracker;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      col, row, min_col, max_col, min_row, max_row;
    bit               seen;
    rect_t            expected_rects[$];
    int unsigned      mismatches;

    function new();
      width_reg  = 1;
      height_reg = 1;
      mismatches = 0;
      restart_frame();
    endfunction

    function int unsigned effective(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
      return v;
    endfunction

    function void restart_frame();
      col     = 0;
      row     = 0;
      min_col = effective(width_reg);
      max_col = 0;
      min_row = effective(height_reg);
      max_row = 0;
      seen    = 0;
    endfunction

    function void set_dimension(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = value;
      end else if (idx == REG_FRAME_HEIGHT) begin
        height_reg = value;
      end
      restart_frame();
    endfunction

    function void take_pixel(pixel_pair_t p);
      int          avg_first, avg_second, diff, limit;
      int unsigned ew, eh;
      rect_t       r;
      limit = CHANGE_THRESHOLD;
      ew = effective(width_reg);
      eh = effective(height_reg);
      avg_first = (int'(p.first_red) + int'(p.first_green) + int'(p.first_blue)
                   + int'(p.first_alpha)) / 4;
      avg_second = (int'(p.second_red) + int'(p.second_green) + int'(p.second_blue)
                    + int'(p.second_alpha)) / 4;
      diff = avg_first - avg_second;
      if (diff >= limit || diff <= -limit) begin
        if (!seen || col < min_col) min_col = col;
        if (!seen || col > max_col) max_col = col;
        if (!seen || row < min_row) min_row = row;
        if (!seen || row > max_row) max_row = row;
        seen = 1;
      end
      if (col >= ew - 1 && row >= eh - 1) begin
        if (seen) begin
          r.rect_x      = 13'(min_col);
          r.rect_y      = 13'(min_row);
          r.rect_width  = 16'(max_col - min_col + 1);
          r.rect_height = 16'(max_row - min_row + 1);
          r.any_changed = 1'b1;
        end else begin
          // no change: dimensions and wrapped extents
          r.rect_x      = 13'(ew);
          r.rect_y      = 13'(eh);
          r.rect_width  = 16'(1 - ew);
          r.rect_height = 16'(1 - eh);
          r.any_changed = 1'b0;
        end
        expected_rects.insert(expected_rects.size(), r);
        restart_frame();
      end else if (col >= ew - 1) begin
        col = 0;
        row++;
      end else begin
        col++;
      end
    endfunction

    function void check_rect(rect_t got);
      rect_t want;
      if (expected_rects.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected rectangle: x=%0d y=%0d w=%0d h=%0d changed=%0b",
                   got.rect_x, got.rect_y, got.rect_width, got.rect_height,
                   got.any_changed);
        return;
      end
      want = expected_rects.pop_front();
      if (got.rect_x !== want.rect_x || got.rect_y !== want.rect_y ||
          got.rect_width !== want.rect_width || got.rect_height !== want.rect_height ||
          got.any_changed !== want.any_changed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("rectangle mismatch: expected x=%0d y=%0d w=%0d h=%0d changed=%0b, %s",
                   want.rect_x, want.rect_y, want.rect_width, want.rect_height,
                   want.any_changed,
                   $sformatf("got x=%0d y=%0d w=%0d h=%0d changed=%0b",
                             got.rect_x, got.rect_y, got.rect_width, got.rect_height,
                             got.any_changed));
      end
    endfunction

    function int unsigned pending();
      return expected_rects.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  fdbb_pix_if  pix_if ();
  fdbb_rect_if rect_if ();

  frame_rect_tracker tracker;
  bit                idle_on;
  int unsigned       ready_hold_cycles;

  frame_difference_bounding_box_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_in      (pix_if),
    .rect_out    (rect_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_wait();
    return idle_on ? $urandom_range(0, 14) : 0;
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] c, int d);
    int v;
    v = int'(c) + d;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // permille: share of pixels whose second value is fully random
  function automatic pixel_pair_t make_pixel(int unsigned permille);
    pixel_pair_t p;
    int unsigned pick;
    int          d;
    p = pixel_pair_t'({$urandom(), $urandom()});
    pick = $urandom_range(0, 999);
    if (pick >= permille) begin
      if (pick < permille + 60) begin
        // shift the whole pixel to land near the threshold
        d = $urandom_range(6, 9);
        if ($urandom_range(0, 1) == 1) d = -d;
        p.second_red   = nudge(p.first_red, d);
        p.second_green = nudge(p.first_green, d);
        p.second_blue  = nudge(p.first_blue, d);
        p.second_alpha = nudge(p.first_alpha, d);
      end else begin
        p.second_red   = nudge(p.first_red, int'($urandom_range(0, 6)) - 3);
        p.second_green = nudge(p.first_green, int'($urandom_range(0, 6)) - 3);
        p.second_blue  = nudge(p.first_blue, int'($urandom_range(0, 6)) - 3);
        p.second_alpha = nudge(p.first_alpha, int'($urandom_range(0, 6)) - 3);
      end
    end
    return p;
  endfunction

  task automatic send_pixel(input pixel_pair_t pair);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= pair;
    do @(posedge clk_i); while (!pix_if.ready);
    tracker.take_pixel(pair);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    tracker.set_dimension(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every expected rectangle, then let the pipeline settle.
  task automatic drain();
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_frames(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input int unsigned count, input int unsigned permille,
                            input bit pause_midway);
    write_register(REG_FRAME_WIDTH, w);
    write_register(REG_FRAME_HEIGHT, h);
    for (int unsigned k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) begin
        pix_if.valid <= 1'b0;
        drain();
      end
      send_pixel(make_pixel(permille));
    end
    pix_if.valid <= 1'b0;
    drain();
  endtask

  initial begin : rect_sink
    rect_t       got;
    int unsigned stall;
    rect_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (ready_hold_cycles != 0) begin
        stall = ready_hold_cycles;
        ready_hold_cycles = 0;
      end else begin
        stall = draw_wait();
      end
      if (stall != 0) begin
        rect_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rect_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rect_if.valid && rect_if.ready));
      got = rect_if.data;
      tracker.check_rect(got);
    end
  end

  initial begin : stimulus
    pixel_pair_t  hot, calm;
    int unsigned  random_items, phase, wi, hi, count, permille;
    logic [CFG_W-1:0] w, h;
    bit           pause;
    tracker = new();
    idle_on = 1'b1;
    ready_hold_cycles = 0;
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_FRAME_WIDTH;
    cfg_wdata    <= '0;
    pix_if.valid <= 1'b0;
    pix_if.data  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 1x1 frames after reset: every pixel closes a frame
    send_pixel(pixel_pair_t'({32'h00000000, 32'h00000000}));
    send_pixel(pixel_pair_t'({32'hFFFFFFFF, 32'hFFFFFFFF}));
    send_pixel(pixel_pair_t'({32'h08080808, 32'h00000000}));
    send_pixel(pixel_pair_t'({32'h07070707, 32'h00000000}));
    send_pixel(pixel_pair_t'({32'h00000000, 32'h08080808}));
    send_pixel(pixel_pair_t'({32'h00000000, 32'h07070707}));
    send_pixel(pixel_pair_t'({32'hFFFFFFFF, 32'h00000000}));
    send_pixel(pixel_pair_t'({32'h00000000, 32'hFFFFFFFF}));
    // averages floor before the difference is taken
    send_pixel(pixel_pair_t'({32'h09090908, 32'h01010100}));
    send_pixel(pixel_pair_t'({32'h08080807, 32'h00000000}));
    send_pixel(pixel_pair_t'({32'h08080808, 32'h00000003}));
    send_pixel(pixel_pair_t'({32'hAA55AA55, 32'h55AA55AA}));
    pix_if.valid <= 1'b0;
    drain();

    // 3x2: one frame with a box, one without change, then a cut-off frame
    write_register(REG_FRAME_WIDTH, 13'd3);
    write_register(REG_FRAME_HEIGHT, 13'd2);
    hot  = pixel_pair_t'({32'h40404040, 32'h00000000});
    calm = pixel_pair_t'({32'h12345678, 32'h12345678});
    for (int unsigned k = 0; k < 6; k++) send_pixel((k == 2 || k == 4) ? hot : calm);
    for (int unsigned k = 0; k < 6; k++) send_pixel(calm);
    send_pixel(hot);
    send_pixel(calm);
    pix_if.valid <= 1'b0;
    drain();

    random_items = 0;
    phase = 0;
    while (random_items < 700) begin
      wi = $urandom_range(1, 8);
      hi = $urandom_range(1, 6);
      // zero acts as one
      w = (wi == 1 && $urandom_range(0, 1) == 1) ? '0 : CFG_W'(wi);
      h = (hi == 1 && $urandom_range(0, 1) == 1) ? '0 : CFG_W'(hi);
      count = wi * hi * $urandom_range(1, 5);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, wi * hi);
      case ($urandom_range(0, 3))
        0: permille = 0;
        1: permille = 20;
        2: permille = 150;
        default: permille = 500;
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      pause = (phase == 1) || ($urandom_range(0, 7) == 0);
      if (phase == 0) begin
        // hold off the result side while pixels keep coming
        w = 13'd1;
        h = 13'd1;
        count = 60;
        idle_on = 1'b0;
        pause = 1'b0;
        ready_hold_cycles = 300;
      end
      run_frames(w, h, count, permille, pause);
      random_items += count;
      phase++;
    end

    // frames larger than the limit, cut off before they close
    idle_on = 1'b0;
    run_frames(13'h1FFF, 13'd1, 60, 2, 1'b0);
    idle_on = 1'b1;
    run_frames(13'd1, 13'h1FFF, 60, 2, 1'b0);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd15_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
